[rtl/i2p_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared constants, types and helper functions of the infix to postfix
// converter: character codes, stack codes, microcode fields and step names.
// ----------------------------------------------------------------------------
package i2p_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int SYM_W       = 8;
    localparam int CODE_W      = 3;
    localparam int ERR_W       = 2;

    // ASCII characters of interest.
    localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [SYM_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [SYM_W-1:0] CH_UA     = 8'h41;
    localparam logic [SYM_W-1:0] CH_UZ     = 8'h5A;
    localparam logic [SYM_W-1:0] CH_LA     = 8'h61;
    localparam logic [SYM_W-1:0] CH_LZ     = 8'h7A;

    // Codes held in the operator stack.
    localparam logic [CODE_W-1:0] CODE_NONE   = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ADD    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_SUB    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_MUL    = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DIV    = 3'd4;
    localparam logic [CODE_W-1:0] CODE_POW    = 3'd5;
    localparam logic [CODE_W-1:0] CODE_LPAREN = 3'd6;

    // Error field values.
    localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVF  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNF  = 2'd2;

    // Input item classes.
    typedef enum logic [2:0] {
        CLS_IGNORE,
        CLS_LETTER,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_OPER,
        CLS_END
    } t_cls;

    // Microprogram steps.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LETTER,
        S_OPLOOP,
        S_OPTEST,
        S_OPPOP,
        S_PUSH,
        S_DOPUSH,
        S_OVF,
        S_RPLOOP,
        S_RPTEST,
        S_RPPOP,
        S_UNF,
        S_DISCARD,
        S_ENDLOOP,
        S_ENDPOP,
        S_MARK
    } t_step;

    // Jump conditions.
    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_EMPTY,
        J_FULL,
        J_PREC_LT,
        J_TOP_LP,
        J_DISPATCH
    } t_cond;

    // Source of an emitted result.
    typedef enum logic [2:0] {
        E_SYM,
        E_TOP,
        E_OVF,
        E_UNF,
        E_MARK
    } t_esel;

    typedef struct packed {
        logic   wait_in;
        logic   fin;
        logic   emit;
        t_esel  esel;
        logic   pop;
        logic   push;
        logic   rd;
        logic   clr;
        t_cond  cond;
        t_step  tgt;
    } t_ctl;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             expr_end;
        logic [ERR_W-1:0] err;
    } t_res;

    function automatic logic [CODE_W-1:0] f_op_code(input logic [SYM_W-1:0] sym);
        logic [CODE_W-1:0] code;
        case (sym)
            CH_PLUS:  code = CODE_ADD;
            CH_MINUS: code = CODE_SUB;
            CH_STAR:  code = CODE_MUL;
            CH_SLASH: code = CODE_DIV;
            CH_CARET: code = CODE_POW;
            default:  code = CODE_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [SYM_W-1:0] f_code_char(input logic [CODE_W-1:0] code);
        logic [SYM_W-1:0] ch;
        case (code)
            CODE_ADD:    ch = CH_PLUS;
            CODE_SUB:    ch = CH_MINUS;
            CODE_MUL:    ch = CH_STAR;
            CODE_DIV:    ch = CH_SLASH;
            CODE_POW:    ch = CH_CARET;
            CODE_LPAREN: ch = CH_LPAREN;
            default:     ch = '0;
        endcase
        return ch;
    endfunction

    function automatic logic [1:0] f_prec(input logic [CODE_W-1:0] code);
        logic [1:0] p;
        case (code)
            CODE_ADD, CODE_SUB: p = 2'd1;
            CODE_MUL, CODE_DIV: p = 2'd2;
            CODE_POW:           p = 2'd3;
            default:            p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic t_cls f_class(input logic op, input logic [SYM_W-1:0] sym);
        t_cls cls;
        if (op) begin
            cls = CLS_END;
        end else if ((sym >= CH_UA && sym <= CH_UZ) || (sym >= CH_LA && sym <= CH_LZ)) begin
            cls = CLS_LETTER;
        end else if (sym == CH_LPAREN) begin
            cls = CLS_LPAREN;
        end else if (sym == CH_RPAREN) begin
            cls = CLS_RPAREN;
        end else if (f_op_code(sym) != CODE_NONE) begin
            cls = CLS_OPER;
        end else begin
            cls = CLS_IGNORE;
        end
        return cls;
    endfunction

endpackage
`default_nettype wire

[rtl/i2p_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_in_if
// Input channel: one infix character or an end-of-expression item.
// ----------------------------------------------------------------------------
interface i2p_in_if import i2p_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [SYM_W-1:0] symbol;

    modport source (output valid, output op, output symbol, input ready);
    modport sink   (input valid, input op, input symbol, output ready);
endinterface
`default_nettype wire

[rtl/i2p_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_out_if
// Output channel: one postfix character, end marker or error result.
// ----------------------------------------------------------------------------
interface i2p_out_if import i2p_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] out_symbol;
    logic             expr_end;
    logic [ERR_W-1:0] error;
    logic             last;

    modport source (output valid, output out_symbol, output expr_end, output error,
                    output last, input ready);
    modport sink   (input valid, input out_symbol, input expr_end, input error,
                    input last, output ready);
endinterface
`default_nettype wire

[rtl/infix_to_postfix_converter_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard infix to postfix converter driven by a microcoded sequencer
// over an operator stack memory.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                              | Transfer
//  i_in    | in  | op, symbol                           | valid && ready
//  o_out   | out | out_symbol, expr_end, error, last     | valid && ready
//
//  Per item: a letter is emitted, '(' is pushed, an operator pops entries
//  until a lower one or an empty stack and is then pushed, ')' pops down to
//  its '(' (an underflow error if none), end of expression pops every entry.
//  Each pop costs one stack memory read plus its test.
//  Reset clears the step counter, the stack count and both result valid flags.
//  A result waits in a pending register until the next one (or the end of
//  the item) decides its last flag; the sequencer holds only when that move
//  finds the output register full and not taken.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top import i2p_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    i2p_in_if.sink    i_in,
    i2p_out_if.source o_out
);

    function automatic t_ctl f_rom(input t_step pc);
        t_ctl c;
        c = '{wait_in: 1'b0, fin: 1'b0, emit: 1'b0, esel: E_SYM, pop: 1'b0,
              push: 1'b0, rd: 1'b0, clr: 1'b0, cond: J_NEXT, tgt: S_IDLE};
        case (pc)
            S_IDLE: begin
                c.wait_in = 1'b1;
                c.fin     = 1'b1;
                c.cond    = J_DISPATCH;
            end
            S_LETTER: begin
                c.emit = 1'b1;
                c.esel = E_SYM;
                c.cond = J_ALWAYS;
            end
            S_OPLOOP: begin
                c.rd   = 1'b1;
                c.cond = J_EMPTY;
                c.tgt  = S_PUSH;
            end
            S_OPTEST: begin
                c.cond = J_PREC_LT;
                c.tgt  = S_PUSH;
            end
            S_OPPOP: begin
                c.emit = 1'b1;
                c.esel = E_TOP;
                c.pop  = 1'b1;
                c.cond = J_ALWAYS;
                c.tgt  = S_OPLOOP;
            end
            S_PUSH: begin
                c.cond = J_FULL;
                c.tgt  = S_OVF;
            end
            S_DOPUSH: begin
                c.push = 1'b1;
                c.cond = J_ALWAYS;
            end
            S_OVF: begin
                c.emit = 1'b1;
                c.esel = E_OVF;
                c.clr  = 1'b1;
                c.cond = J_ALWAYS;
            end
            S_RPLOOP: begin
                c.rd   = 1'b1;
                c.cond = J_EMPTY;
                c.tgt  = S_UNF;
            end
            S_RPTEST: begin
                c.cond = J_TOP_LP;
                c.tgt  = S_DISCARD;
            end
            S_RPPOP: begin
                c.emit = 1'b1;
                c.esel = E_TOP;
                c.pop  = 1'b1;
                c.cond = J_ALWAYS;
                c.tgt  = S_RPLOOP;
            end
            S_UNF: begin
                c.emit = 1'b1;
                c.esel = E_UNF;
                c.cond = J_ALWAYS;
            end
            S_DISCARD: begin
                c.pop  = 1'b1;
                c.cond = J_ALWAYS;
            end
            S_ENDLOOP: begin
                c.rd   = 1'b1;
                c.cond = J_EMPTY;
                c.tgt  = S_MARK;
            end
            S_ENDPOP: begin
                c.emit = 1'b1;
                c.esel = E_TOP;
                c.pop  = 1'b1;
                c.cond = J_ALWAYS;
                c.tgt  = S_ENDLOOP;
            end
            S_MARK: begin
                c.emit = 1'b1;
                c.esel = E_MARK;
                c.cond = J_ALWAYS;
            end
            default: begin
                c.cond = J_ALWAYS;
            end
        endcase
        return c;
    endfunction

    logic [CODE_W-1:0] r_stack [STACK_DEPTH];

    t_step             r_upc;
    t_step             n_upc;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [SYM_W-1:0]  r_sym;
    logic [CODE_W-1:0] r_code;
    logic [CODE_W-1:0] r_top;
    logic              r_pv;
    t_res              r_pend;
    logic              r_ov;
    t_res              r_out;
    logic              r_olast;

    t_ctl              ctl;
    t_cls              cls;
    t_step             dispatch;
    t_res              emit_val;
    logic              out_busy;
    logic              stall;
    logic              act;
    logic              accept;
    logic              jump;
    logic [ADDR_W-1:0] rd_addr;

    always_comb begin
        ctl      = f_rom(r_upc);
        out_busy = r_ov && !o_out.ready;
        // Only a step that moves the pending result needs a free output slot.
        stall    = (ctl.emit || ctl.fin) && r_pv && out_busy;
        act      = !stall;
        accept   = i_in.valid && ctl.wait_in && act;
        cls      = f_class(i_in.op, i_in.symbol);
        rd_addr  = ADDR_W'(r_cnt - CNT_W'(1));

        case (cls)
            CLS_LETTER: dispatch = S_LETTER;
            CLS_LPAREN: dispatch = S_PUSH;
            CLS_RPAREN: dispatch = S_RPLOOP;
            CLS_OPER:   dispatch = S_OPLOOP;
            CLS_END:    dispatch = S_ENDLOOP;
            default:    dispatch = S_IDLE;
        endcase

        case (ctl.cond)
            J_ALWAYS:  jump = 1'b1;
            J_EMPTY:   jump = (r_cnt == '0);
            J_FULL:    jump = (r_cnt == CNT_W'(STACK_DEPTH));
            J_PREC_LT: jump = (f_prec(r_top) < f_prec(r_code));
            J_TOP_LP:  jump = (r_top == CODE_LPAREN);
            default:   jump = 1'b0;
        endcase

        if (stall) begin
            n_upc = r_upc;
        end else if (ctl.cond == J_DISPATCH) begin
            n_upc = accept ? dispatch : S_IDLE;
        end else if (jump) begin
            n_upc = ctl.tgt;
        end else begin
            n_upc = t_step'(r_upc + 4'd1);
        end

        n_cnt = r_cnt;
        if (act) begin
            if (ctl.clr) begin
                n_cnt = '0;
            end else if (ctl.push) begin
                n_cnt = r_cnt + CNT_W'(1);
            end else if (ctl.pop) begin
                n_cnt = r_cnt - CNT_W'(1);
            end
        end

        case (ctl.esel)
            E_SYM:   emit_val = '{sym: r_sym, expr_end: 1'b0, err: ERR_NONE};
            E_TOP:   emit_val = '{sym: f_code_char(r_top), expr_end: 1'b0, err: ERR_NONE};
            E_OVF:   emit_val = '{sym: '0, expr_end: 1'b0, err: ERR_OVF};
            E_UNF:   emit_val = '{sym: '0, expr_end: 1'b0, err: ERR_UNF};
            E_MARK:  emit_val = '{sym: '0, expr_end: 1'b1, err: ERR_NONE};
            default: emit_val = '{sym: '0, expr_end: 1'b0, err: ERR_NONE};
        endcase
    end

    // Operator stack: one write port for pushes, one registered read of the top.
    always_ff @(posedge i_clk) begin
        if (act && ctl.push) begin
            r_stack[r_cnt[ADDR_W-1:0]] <= r_code;
        end
        if (ctl.rd) begin
            r_top <= r_stack[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
            r_cnt <= '0;
            r_pv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_upc <= n_upc;
            r_cnt <= n_cnt;

            if (accept) begin
                r_sym  <= i_in.symbol;
                r_code <= (cls == CLS_LPAREN) ? CODE_LPAREN : f_op_code(i_in.symbol);
            end

            // A new result or the end of the item releases the pending one.
            if (act && (ctl.emit || ctl.fin) && r_pv) begin
                r_out   <= r_pend;
                r_olast <= ctl.fin;
                r_ov    <= 1'b1;
            end else if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end

            if (act && ctl.emit) begin
                r_pend <= emit_val;
                r_pv   <= 1'b1;
            end else if (act && ctl.fin) begin
                r_pv <= 1'b0;
            end
        end
    end

    assign i_in.ready       = ctl.wait_in && act;
    assign o_out.valid      = r_ov;
    assign o_out.out_symbol = r_out.sym;
    assign o_out.expr_end   = r_out.expr_end;
    assign o_out.error      = r_out.err;
    assign o_out.last       = r_olast;

endmodule
`default_nettype wire

[rtl/i2p_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_checker
// Port-level checks of the infix to postfix converter, bound to the top level.
// ----------------------------------------------------------------------------
module i2p_checker import i2p_pkg::*; (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_out_valid,
    input wire             i_out_ready,
    input wire [SYM_W-1:0] i_out_symbol,
    input wire             i_out_expr_end,
    input wire [ERR_W-1:0] i_out_error,
    input wire             i_out_last
);

    // A result offered and not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_symbol) && $stable(i_out_error) &&
            $stable(i_out_expr_end) && $stable(i_out_last))
        else $error("output result changed while stalled");

    // The end marker carries no character, no error and closes its item.
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_expr_end |->
            i_out_symbol == '0 && i_out_error == ERR_NONE && i_out_last)
        else $error("malformed end marker");

    // Error results carry no character and are always the last of their item.
    a_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error != ERR_NONE |->
            i_out_symbol == '0 && !i_out_expr_end && i_out_last &&
            (i_out_error == ERR_OVF || i_out_error == ERR_UNF))
        else $error("malformed error result");

    // Nothing is offered in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

endmodule

bind infix_to_postfix_converter_top i2p_checker u_i2p_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_symbol   (o_out.out_symbol),
    .i_out_expr_end (o_out.expr_end),
    .i_out_error    (o_out.error),
    .i_out_last     (o_out.last)
);
`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the infix to postfix converter. A directed table of
// characters comes first. Random expressions, broken sequences and deep
// nestings that overflow the operator stack follow. An operator-stack model
// inside the bench predicts every postfix result. The monitor compares each
// output transfer field by field against the oldest prediction. Both
// channels idle at random, and the output side stalls once for a long time.
// ----------------------------------------------------------------------------
module tb;
    import i2p_pkg::*;

    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 285;
    localparam int TAIL_CALM   = 60;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 60;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             expr_end;
        logic [ERR_W-1:0] err;
        logic             last;
    } t_post;

    typedef struct packed {
        logic             op;
        logic [SYM_W-1:0] sym;
        logic             typed;
        t_post            want;
    } t_item;

    localparam t_post NO_POST = '0;

    // Rows with a typed result carry exactly one known result. All other rows
    // go through the stack model.
    localparam t_item DIR_TAB [N_DIRECTED] = '{
        '{1'b1, 8'hFF,     1'b1, '{8'h00, 1'b1, ERR_NONE, 1'b1}},
        '{1'b0, CH_RPAREN, 1'b1, '{8'h00, 1'b0, ERR_UNF,  1'b1}},
        '{1'b0, CH_UA,     1'b1, '{CH_UA, 1'b0, ERR_NONE, 1'b1}},
        '{1'b0, CH_LZ,     1'b1, '{CH_LZ, 1'b0, ERR_NONE, 1'b1}},
        '{1'b0, 8'h00,     1'b0, NO_POST},
        '{1'b0, 8'hFF,     1'b0, NO_POST},
        '{1'b0, 8'h40,     1'b0, NO_POST},
        '{1'b0, 8'h7B,     1'b0, NO_POST},
        '{1'b0, "a",       1'b0, NO_POST},
        '{1'b0, CH_PLUS,   1'b0, NO_POST},
        '{1'b0, "b",       1'b0, NO_POST},
        '{1'b0, CH_STAR,   1'b0, NO_POST},
        '{1'b0, CH_LPAREN, 1'b0, NO_POST},
        '{1'b0, "c",       1'b0, NO_POST},
        '{1'b0, CH_MINUS,  1'b0, NO_POST},
        '{1'b0, "d",       1'b0, NO_POST},
        '{1'b0, CH_RPAREN, 1'b0, NO_POST},
        '{1'b0, CH_SLASH,  1'b0, NO_POST},
        '{1'b0, "e",       1'b0, NO_POST},
        '{1'b0, CH_CARET,  1'b0, NO_POST},
        '{1'b0, "f",       1'b0, NO_POST},
        '{1'b0, CH_PLUS,   1'b0, NO_POST},
        '{1'b0, CH_RPAREN, 1'b0, NO_POST},
        '{1'b0, CH_LPAREN, 1'b0, NO_POST},
        '{1'b1, 8'h00,     1'b0, NO_POST}
    };

    logic i_clk;
    logic i_rst_n;
    logic no_idle;
    logic hold_req;

    i2p_in_if  in_if ();
    i2p_out_if out_if ();

    infix_to_postfix_converter_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [CODE_W-1:0] op_stack [STACK_DEPTH];
    int    op_depth = 0;
    int    deepest  = 0;
    t_post step_q    [$];
    t_post postfix_q [$];
    t_item stim_q    [$];

    int n_bad     = 0;
    int n_checked = 0;
    int n_real    = 0;
    int n_ovf     = 0;
    int n_unf     = 0;
    int n_marks   = 0;

    function automatic logic is_letter(input logic [SYM_W-1:0] c);
        return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
    endfunction

    function automatic logic [CODE_W-1:0] oper_code(input logic [SYM_W-1:0] c);
        logic [CODE_W-1:0] code;
        case (c)
            CH_PLUS:  code = CODE_ADD;
            CH_MINUS: code = CODE_SUB;
            CH_STAR:  code = CODE_MUL;
            CH_SLASH: code = CODE_DIV;
            CH_CARET: code = CODE_POW;
            default:  code = CODE_NONE;
        endcase
        return code;
    endfunction

    function automatic int rank(input logic [CODE_W-1:0] code);
        int r;
        case (code)
            CODE_ADD, CODE_SUB: r = 1;
            CODE_MUL, CODE_DIV: r = 2;
            CODE_POW:           r = 3;
            default:            r = 0;
        endcase
        return r;
    endfunction

    function automatic logic [SYM_W-1:0] code_char(input logic [CODE_W-1:0] code);
        logic [SYM_W-1:0] c;
        case (code)
            CODE_ADD:    c = CH_PLUS;
            CODE_SUB:    c = CH_MINUS;
            CODE_MUL:    c = CH_STAR;
            CODE_DIV:    c = CH_SLASH;
            CODE_POW:    c = CH_CARET;
            CODE_LPAREN: c = CH_LPAREN;
            default:     c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] rand_letter();
        if ($urandom_range(0, 1)) begin
            return 8'($urandom_range(CH_UA, CH_UZ));
        end
        return 8'($urandom_range(CH_LA, CH_LZ));
    endfunction

    function automatic logic [SYM_W-1:0] rand_oper();
        logic [SYM_W-1:0] c;
        case ($urandom_range(0, 4))
            0:       c = CH_PLUS;
            1:       c = CH_MINUS;
            2:       c = CH_STAR;
            3:       c = CH_SLASH;
            default: c = CH_CARET;
        endcase
        return c;
    endfunction

    task automatic pop_emit();
        op_depth--;
        step_q.push_back('{code_char(op_stack[op_depth]), 1'b0, ERR_NONE, 1'b0});
    endtask

    task automatic push_code(input logic [CODE_W-1:0] code);
        if (op_depth >= STACK_DEPTH) begin
            op_depth = 0;
            step_q.push_back('{8'h00, 1'b0, ERR_OVF, 1'b0});
        end else begin
            op_stack[op_depth] = code;
            op_depth++;
            if (op_depth > deepest) begin
                deepest = op_depth;
            end
        end
    endtask

    // Advances the stack model by one input character and leaves its postfix
    // results in step_q.
    task automatic postfix_step(input logic op, input logic [SYM_W-1:0] sym);
        logic [CODE_W-1:0] code;
        step_q.delete();
        code = oper_code(sym);
        if (op) begin
            while (op_depth > 0) pop_emit();
            step_q.push_back('{8'h00, 1'b1, ERR_NONE, 1'b0});
        end else if (is_letter(sym)) begin
            step_q.push_back('{sym, 1'b0, ERR_NONE, 1'b0});
        end else if (sym == CH_LPAREN) begin
            push_code(CODE_LPAREN);
        end else if (sym == CH_RPAREN) begin
            while (op_depth > 0 && op_stack[op_depth-1] != CODE_LPAREN) pop_emit();
            if (op_depth == 0) begin
                step_q.push_back('{8'h00, 1'b0, ERR_UNF, 1'b0});
            end else begin
                op_depth--;
            end
        end else if (code != CODE_NONE) begin
            while (op_depth > 0 && rank(op_stack[op_depth-1]) >= rank(code)) pop_emit();
            push_code(code);
        end
        if (step_q.size() > 0) begin
            step_q[step_q.size()-1].last = 1'b1;
        end
    endtask

    task automatic add_item(input logic op, input logic [SYM_W-1:0] sym);
        t_item it;
        it = '{op, sym, 1'b0, NO_POST};
        stim_q.push_back(it);
        if (op || is_letter(sym) || sym == CH_LPAREN || sym == CH_RPAREN ||
            oper_code(sym) != CODE_NONE) begin
            n_real++;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        n_bad++;
        if (n_bad <= 50) begin
            $display("MISMATCH at result %0d: %s got 0x%0h expected 0x%0h",
                     n_checked, what, got, exp_val);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TIMEOUT with %0d results still expected", postfix_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Output side: short random stalls, one long hold-off so that the block
    // backs up into its input, and no new short stall starts while no_idle is set.
    initial begin
        int stall;
        bit held;
        stall = 0;
        held  = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end else if (stall == 0 && !no_idle && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 10);
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                stall--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_post exp_res;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (postfix_q.size() == 0) begin
                report_mismatch("unexpected result, symbol", out_if.out_symbol, 0);
            end else begin
                exp_res = postfix_q.pop_front();
                if (out_if.out_symbol !== exp_res.sym) begin
                    report_mismatch("out_symbol", out_if.out_symbol, exp_res.sym);
                end
                if (out_if.expr_end !== exp_res.expr_end) begin
                    report_mismatch("expr_end", out_if.expr_end, exp_res.expr_end);
                end
                if (out_if.error !== exp_res.err) begin
                    report_mismatch("error", out_if.error, exp_res.err);
                end
                if (out_if.last !== exp_res.last) begin
                    report_mismatch("last", out_if.last, exp_res.last);
                end
            end
            n_checked++;
        end
    end

    initial begin
        t_item it;
        int    i;
        int    seq;
        int    kind;
        int    nest;
        int    len;
        int    ops_left;
        int    open_n;
        bit    need_operand;
        bit    calm;

        in_if.valid  <= 1'b0;
        in_if.op     <= 1'b0;
        in_if.symbol <= '0;
        no_idle      <= 1'b0;
        hold_req     <= 1'b0;
        i_rst_n      <= 1'b0;

        for (i = 0; i < N_DIRECTED; i++) begin
            stim_q.push_back(DIR_TAB[i]);
        end

        seq = 0;
        while (stim_q.size() < N_DIRECTED + N_RANDOM) begin
            kind = (seq < 2) ? 0 : $urandom_range(0, 11);
            if (kind == 0) begin
                // Deep nesting: just below, at and above the stack depth.
                if (seq == 0) begin
                    nest = STACK_DEPTH - 1;
                end else if (seq == 1) begin
                    nest = STACK_DEPTH + 1;
                end else begin
                    nest = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
                end
                repeat (nest) add_item(1'b0, CH_LPAREN);
                add_item(1'b0, rand_letter());
                add_item(1'b0, rand_oper());
                add_item(1'b1, 8'($urandom));
            end else if (kind <= 3) begin
                len = $urandom_range(1, 10);
                repeat (len) begin
                    case ($urandom_range(0, 3))
                        0:       add_item(1'b0, 8'($urandom));
                        1:       add_item(1'b0, rand_letter());
                        2:       add_item(1'b0, rand_oper());
                        default: add_item(1'b0, $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
                    endcase
                end
                if ($urandom_range(0, 1)) begin
                    add_item(1'b1, 8'($urandom));
                end
            end else begin
                ops_left     = $urandom_range(0, 10);
                open_n       = 0;
                need_operand = 1'b1;
                while (1) begin
                    if ($urandom_range(0, 9) == 0) begin
                        add_item(1'b0, 8'h20);
                    end
                    if (need_operand) begin
                        if (open_n < 4 && $urandom_range(0, 3) == 0) begin
                            add_item(1'b0, CH_LPAREN);
                            open_n++;
                        end else begin
                            add_item(1'b0, rand_letter());
                            need_operand = 1'b0;
                        end
                    end else if (open_n > 0 && (ops_left == 0 || $urandom_range(0, 2) == 0)) begin
                        add_item(1'b0, CH_RPAREN);
                        open_n--;
                    end else if (ops_left > 0) begin
                        add_item(1'b0, rand_oper());
                        ops_left--;
                        need_operand = 1'b1;
                    end else begin
                        break;
                    end
                end
                add_item(1'b1, 8'($urandom));
            end
            seq++;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < stim_q.size(); i++) begin
            it   = stim_q[i];
            calm = (i >= stim_q.size() - TAIL_CALM) || ((i / 40) % 4 == 1);
            no_idle <= calm;
            if (i == HOLD_AT) begin
                hold_req <= 1'b1;
            end
            if (!calm && $urandom_range(0, 5) == 0) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            in_if.valid  <= 1'b1;
            in_if.op     <= it.op;
            in_if.symbol <= it.sym;
            do @(posedge i_clk); while (!in_if.ready);

            // The transfer happened at this edge.
            postfix_step(it.op, it.sym);
            if (it.typed) begin
                postfix_q.push_back(it.want);
            end else begin
                foreach (step_q[k]) postfix_q.push_back(step_q[k]);
            end
            foreach (step_q[k]) begin
                if (step_q[k].err == ERR_OVF) n_ovf++;
                if (step_q[k].err == ERR_UNF) n_unf++;
                if (step_q[k].expr_end) n_marks++;
            end
        end
        in_if.valid <= 1'b0;

        while (postfix_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Ran %0d characters (%0d directed, %0d not ignored), checked %0d results.",
                 stim_q.size(), N_DIRECTED, n_real, n_checked);
        $display("Saw %0d expression ends, %0d overflows, %0d underflows; stack reached %0d.",
                 n_marks, n_ovf, n_unf, deepest);
        if (n_bad == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/i2p_pkg.sv
rtl/i2p_in_if.sv
rtl/i2p_out_if.sv
rtl/infix_to_postfix_converter_top.sv
rtl/i2p_checker.sv
test/tb.sv
